@@ hdl/ccpc_pkg.sv @@
// Shared types, widths, register codes and divider step for the coverage unit.
package ccpc_pkg;

  localparam int LOGICAL_SIZE = 100;
  localparam int FRAC_SCALE   = 256;

  localparam int IDXW    = 3;   // config register index
  localparam int CFG_DW  = 16;  // config write data
  localparam int CRDW    = 7;   // logical coordinate / stroke
  localparam int COLOR_W = 16;
  localparam int PIX_W   = 6;   // pixel column / row

  localparam int QW   = 16;  // pixel centre, 8 fractional bits
  localparam int SCW  = 15;  // logical coordinate times 256
  localparam int DW   = 17;  // signed pixel minus start
  localparam int VW   = 16;  // signed segment vector
  localparam int LW   = 32;  // squared segment length
  localparam int PRW  = 33;  // one projection product
  localparam int SQ0W = 34;  // square of a DW value
  localparam int PW   = 34;  // projection sum
  localparam int NW   = 48;  // quotient numerator
  localparam int QTW  = 15;  // quotient
  localparam int XW   = 18;  // signed distance to closest point
  localparam int SQW  = 36;  // square of an XW value
  localparam int DSW  = 37;  // squared distance
  localparam int RW   = 30;  // squared radius

  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QTW / DIV_STEPS;

  typedef enum logic [IDXW-1:0] {
    REG_SHAPE_MODE  = 3'd0,
    REG_SEG_START_X = 3'd1,
    REG_SEG_START_Y = 3'd2,
    REG_SEG_END_X   = 3'd3,
    REG_SEG_END_Y   = 3'd4,
    REG_STROKE_SIZE = 3'd5,
    REG_PAINT_COLOR = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                  shape_mode;
    logic [SCW-1:0]        sx;
    logic [SCW-1:0]        sy;
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic [VW-1:0]         vax;
    logic [VW-1:0]         vay;
    logic [LW-1:0]         len2;
    logic [RW-1:0]         r2_full;
    logic [RW-1:0]         r2_half;
    logic [RW-1:0]         r2_cap;
    logic [COLOR_W-1:0]    color;
  } cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] dxs;
    logic signed [DW-1:0] dys;
    logic [DSW-1:0]       d0;
    logic                 le0;
    logic                 ge;
  } geo_t;

  typedef struct packed {
    logic [LW-1:0]  rem;
    logic [QTW-1:0] nl;
    logic [QTW-1:0] q;
  } div_t;

  // One restoring step: bring down a numerator bit, subtract if it fits.
  function automatic div_t div_step(input div_t s, input logic [LW-1:0] d);
    logic [LW:0] t;
    div_t        o;
    t    = {s.rem, s.nl[QTW-1]};
    o.nl = {s.nl[QTW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = LW'(t - {1'b0, d});
      o.q   = {s.q[QTW-2:0], 1'b1};
    end else begin
      o.rem = t[LW-1:0];
      o.q   = {s.q[QTW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ hdl/ccpc_if.sv @@
// Channel interfaces: pixel input, coverage result and config write.
interface ccpc_pix_if #(parameter int CW = 6) ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] pixel_col;
  logic [CW-1:0] pixel_row;
  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface ccpc_res_if #(parameter int CW = 6) ();
  logic          valid;
  logic          ready;
  logic          covered;
  logic [CW-1:0] out_col;
  logic [CW-1:0] out_row;
  logic [15:0]   out_color;
  modport source (output valid, covered, out_col, out_row, out_color, input ready);
  modport sink (input valid, covered, out_col, out_row, out_color, output ready);
endinterface

interface ccpc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/ccpc_cfg.sv @@
// Config registers and the shape terms derived from them.
module ccpc_cfg
  import ccpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ccpc_cfg_if.sink   cfg_wr,
  output cfg_t       cfg
);

  logic                 mode_r;
  logic [CRDW-1:0]      sx_r, sy_r, ex_r, ey_r, stroke_r;
  logic [COLOR_W-1:0]   color_r;

  logic signed [VW-1:0] vx_r, vy_r, vx_nxt, vy_nxt;
  logic [VW-1:0]        vax_r, vay_r, vax_nxt, vay_nxt;
  logic [LW-1:0]        len2_r, len2_nxt;
  logic [RW-1:0]        r2_full_r, r2_half_r, r2_cap_r;
  logic [RW-1:0]        r2_full_nxt, r2_half_nxt, r2_cap_nxt;
  logic signed [2*VW-1:0] vxx, vyy;
  logic [2*CRDW-1:0]    s2;
  logic [2*CRDW-3:0]    h2;
  logic [CRDW-2:0]      half;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      sx_r     <= '0;
      sy_r     <= '0;
      ex_r     <= '0;
      ey_r     <= '0;
      stroke_r <= '0;
      color_r  <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_SHAPE_MODE:  mode_r   <= cfg_wr.data[0];
        REG_SEG_START_X: sx_r     <= cfg_wr.data[CRDW-1:0];
        REG_SEG_START_Y: sy_r     <= cfg_wr.data[CRDW-1:0];
        REG_SEG_END_X:   ex_r     <= cfg_wr.data[CRDW-1:0];
        REG_SEG_END_Y:   ey_r     <= cfg_wr.data[CRDW-1:0];
        REG_STROKE_SIZE: stroke_r <= cfg_wr.data[CRDW-1:0];
        REG_PAINT_COLOR: color_r  <= cfg_wr.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    vx_nxt      = $signed({1'b0, ex_r, 8'b0}) - $signed({1'b0, sx_r, 8'b0});
    vy_nxt      = $signed({1'b0, ey_r, 8'b0}) - $signed({1'b0, sy_r, 8'b0});
    vax_nxt     = vx_nxt[VW-1] ? VW'(-vx_nxt) : vx_nxt;
    vay_nxt     = vy_nxt[VW-1] ? VW'(-vy_nxt) : vy_nxt;
    vxx         = vx_nxt * vx_nxt;
    vyy         = vy_nxt * vy_nxt;
    len2_nxt    = LW'($unsigned(vxx)) + LW'($unsigned(vyy));
    s2          = stroke_r * stroke_r;
    half        = stroke_r[CRDW-1:1];
    h2          = half * half;
    r2_full_nxt = {s2, 16'b0};
    r2_half_nxt = RW'({h2, 16'b0});
    r2_cap_nxt  = RW'({s2, 14'b0});
  end

  // Derived terms are registered and settle in the cycle after a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r      <= '0;
      vy_r      <= '0;
      vax_r     <= '0;
      vay_r     <= '0;
      len2_r    <= '0;
      r2_full_r <= '0;
      r2_half_r <= '0;
      r2_cap_r  <= '0;
    end else begin
      vx_r      <= vx_nxt;
      vy_r      <= vy_nxt;
      vax_r     <= vax_nxt;
      vay_r     <= vay_nxt;
      len2_r    <= len2_nxt;
      r2_full_r <= r2_full_nxt;
      r2_half_r <= r2_half_nxt;
      r2_cap_r  <= r2_cap_nxt;
    end
  end

  always_comb begin
    cfg.shape_mode = mode_r;
    cfg.sx         = {sx_r, 8'b0};
    cfg.sy         = {sy_r, 8'b0};
    cfg.vx         = vx_r;
    cfg.vy         = vy_r;
    cfg.vax        = vax_r;
    cfg.vay        = vay_r;
    cfg.len2       = len2_r;
    cfg.r2_full    = r2_full_r;
    cfg.r2_half    = r2_half_r;
    cfg.r2_cap     = r2_cap_r;
    cfg.color      = color_r;
  end

  a_len2_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (len2_r == '0) == (vx_r == '0 && vy_r == '0))
    else $error("squared length disagrees with segment vector");

endmodule

@@ hdl/ccpc_front.sv @@
// Front pipeline: pixel centre, projection onto the segment, quotient numerators.
module ccpc_front
  import ccpc_pkg::*;
#(
  parameter int ICON_PIXELS = 64,
  parameter int CW          = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  ccpc_pix_if.sink          in_pix,
  input  cfg_t              cfg,
  output logic              o_valid,
  input  logic              o_ready,
  output logic [NW-1:0]     o_num_x,
  output logic [NW-1:0]     o_num_y,
  output geo_t              o_geo,
  output logic [CW-1:0]     o_col,
  output logic [CW-1:0]     o_row
);

  localparam int NST = 4;
  localparam int TBL = 2 ** CW;

  logic [NST-1:0] v_r, adv;
  logic [QW-1:0]  ctr_tbl [TBL];

  for (genvar g = 0; g < TBL; g++) begin : g_tbl
    localparam int CQ = ((2 * g + 1) * LOGICAL_SIZE * FRAC_SCALE) / (2 * ICON_PIXELS);
    assign ctr_tbl[g] = QW'(CQ);
  end

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || o_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end
  assign in_pix.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_pix.valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 0: centre lookup, offset from start
  logic [CW-1:0]        col0_r, row0_r;
  logic signed [DW-1:0] dxs0_r, dys0_r, dxs0_nxt, dys0_nxt;

  assign dxs0_nxt = $signed({1'b0, ctr_tbl[in_pix.pixel_col]}) - $signed({2'b0, cfg.sx});
  assign dys0_nxt = $signed({1'b0, ctr_tbl[in_pix.pixel_row]}) - $signed({2'b0, cfg.sy});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      col0_r <= in_pix.pixel_col;
      row0_r <= in_pix.pixel_row;
      dxs0_r <= dxs0_nxt;
      dys0_r <= dys0_nxt;
    end
  end

  // Stage 1: projection products and start-distance squares
  logic [CW-1:0]          col1_r, row1_r;
  logic signed [DW-1:0]   dxs1_r, dys1_r;
  logic signed [PRW-1:0]  pxv1_r, pyv1_r, pxv_nxt, pyv_nxt;
  logic signed [SQ0W-1:0] sqx1_r, sqy1_r, sqx_nxt, sqy_nxt;

  assign pxv_nxt = dxs0_r * cfg.vx;
  assign pyv_nxt = dys0_r * cfg.vy;
  assign sqx_nxt = dxs0_r * dxs0_r;
  assign sqy_nxt = dys0_r * dys0_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      col1_r <= col0_r;
      row1_r <= row0_r;
      dxs1_r <= dxs0_r;
      dys1_r <= dys0_r;
      pxv1_r <= pxv_nxt;
      pyv1_r <= pyv_nxt;
      sqx1_r <= sqx_nxt;
      sqy1_r <= sqy_nxt;
    end
  end

  // Stage 2: projection sum and clamp decision
  logic [CW-1:0]        col2_r, row2_r;
  geo_t                 geo2_r, geo2_nxt;
  logic [LW-1:0]        proj2_r, proj_u_nxt;
  logic signed [PW-1:0] proj_nxt;

  always_comb begin
    proj_nxt       = PW'(pxv1_r) + PW'(pyv1_r);
    geo2_nxt.dxs   = dxs1_r;
    geo2_nxt.dys   = dys1_r;
    geo2_nxt.d0    = DSW'($unsigned(sqx1_r)) + DSW'($unsigned(sqy1_r));
    geo2_nxt.le0   = proj_nxt[PW-1] || (proj_nxt == '0);
    geo2_nxt.ge    = proj_nxt >= $signed({2'b0, cfg.len2});
    // zero the numerator outside the interior so the divider stays in range
    proj_u_nxt     = (!geo2_nxt.le0 && !geo2_nxt.ge) ? proj_nxt[LW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      col2_r  <= col1_r;
      row2_r  <= row1_r;
      geo2_r  <= geo2_nxt;
      proj2_r <= proj_u_nxt;
    end
  end

  // Stage 3: numerators |v| * proj
  logic [CW-1:0] col3_r, row3_r;
  geo_t          geo3_r;
  logic [NW-1:0] numx3_r, numy3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      col3_r  <= col2_r;
      row3_r  <= row2_r;
      geo3_r  <= geo2_r;
      numx3_r <= NW'(proj2_r) * NW'(cfg.vax);
      numy3_r <= NW'(proj2_r) * NW'(cfg.vay);
    end
  end

  assign o_valid = v_r[NST-1];
  assign o_num_x = numx3_r;
  assign o_num_y = numy3_r;
  assign o_geo   = geo3_r;
  assign o_col   = col3_r;
  assign o_row   = row3_r;

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !o_ready |=> v_r[NST-1] && $stable(numx3_r) && $stable(geo3_r))
    else $error("front output changed while stalled");

endmodule

@@ hdl/ccpc_div.sv @@
// Pipelined restoring divider for both axes: numerator over squared length.
module ccpc_div
  import ccpc_pkg::*;
#(
  parameter int SW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           i_valid,
  output logic           i_ready,
  input  logic [NW-1:0]  i_num_x,
  input  logic [NW-1:0]  i_num_y,
  input  logic [SW-1:0]  i_side,
  input  logic [LW-1:0]  len2,
  output logic           o_valid,
  input  logic           o_ready,
  output logic [QTW-1:0] o_qx,
  output logic [QTW-1:0] o_qy,
  output logic [SW-1:0]  o_side
);

  localparam int L = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] v_r, adv;
  div_t                  dx_r [DIV_STAGES];
  div_t                  dy_r [DIV_STAGES];
  div_t                  dx_in [DIV_STAGES];
  div_t                  dy_in [DIV_STAGES];
  div_t                  dx_nxt [DIV_STAGES];
  div_t                  dy_nxt [DIV_STAGES];
  logic [SW-1:0]         side_r [DIV_STAGES];

  always_comb begin
    adv[L] = !v_r[L] || o_ready;
    for (int k = L - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end
  assign i_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= i_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    if (k == 0) begin : g_first
      // quotient fits QTW bits, so the top bits already sit below the divisor
      always_comb begin
        dx_in[k].rem = i_num_x[QTW+LW-1:QTW];
        dx_in[k].nl  = i_num_x[QTW-1:0];
        dx_in[k].q   = '0;
        dy_in[k].rem = i_num_y[QTW+LW-1:QTW];
        dy_in[k].nl  = i_num_y[QTW-1:0];
        dy_in[k].q   = '0;
      end
    end else begin : g_next
      assign dx_in[k] = dx_r[k-1];
      assign dy_in[k] = dy_r[k-1];
    end

    always_comb begin
      dx_nxt[k] = dx_in[k];
      dy_nxt[k] = dy_in[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        dx_nxt[k] = div_step(dx_nxt[k], len2);
        dy_nxt[k] = div_step(dy_nxt[k], len2);
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        dx_r[k]   <= dx_nxt[k];
        dy_r[k]   <= dy_nxt[k];
        side_r[k] <= (k == 0) ? i_side : side_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign o_valid = v_r[L];
  assign o_qx    = dx_r[L].q;
  assign o_qy    = dy_r[L].q;
  assign o_side  = side_r[L];

  a_hold_q: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L] && !o_ready |=> v_r[L] && $stable(dx_r[L].q) && $stable(dy_r[L].q))
    else $error("quotient changed while stalled");

  a_adv_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !adv[0] |-> v_r[L] && !o_ready)
    else $error("divider stalled with room in the pipe");

endmodule

@@ hdl/ccpc_back.sv @@
// Back pipeline: closest point, squared distance, radius compare, result register.
module ccpc_back
  import ccpc_pkg::*;
#(
  parameter int CW = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           i_valid,
  output logic           i_ready,
  input  logic [QTW-1:0] i_qx,
  input  logic [QTW-1:0] i_qy,
  input  geo_t           i_geo,
  input  logic [CW-1:0]  i_col,
  input  logic [CW-1:0]  i_row,
  input  cfg_t           cfg,
  ccpc_res_if.source     out_res
);

  localparam int NST = 3;

  logic [NST-1:0] v_r, adv;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_res.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end
  assign i_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= i_valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 0: offset of the closest point from start, then pixel minus it
  logic signed [XW-1:0] offx, offy, qxs, qys;
  logic signed [XW-1:0] dx0_r, dy0_r;
  logic [DSW-1:0]       d00_r, d01_r;
  logic [CW-1:0]        col0_r, row0_r, col1_r, row1_r;

  always_comb begin
    qxs = $signed({{(XW-QTW){1'b0}}, i_qx});
    qys = $signed({{(XW-QTW){1'b0}}, i_qy});
    if (i_geo.le0) begin
      offx = '0;
      offy = '0;
    end else if (i_geo.ge) begin
      offx = XW'(cfg.vx);
      offy = XW'(cfg.vy);
    end else begin
      offx = cfg.vx[VW-1] ? -qxs : qxs;
      offy = cfg.vy[VW-1] ? -qys : qys;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx0_r  <= XW'(i_geo.dxs) - offx;
      dy0_r  <= XW'(i_geo.dys) - offy;
      d00_r  <= i_geo.d0;
      col0_r <= i_col;
      row0_r <= i_row;
    end
  end

  // Stage 1: squares
  logic signed [SQW-1:0] sqx1_r, sqy1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sqx1_r <= dx0_r * dx0_r;
      sqy1_r <= dy0_r * dy0_r;
      d01_r  <= d00_r;
      col1_r <= col0_r;
      row1_r <= row0_r;
    end
  end

  // Stage 2: compare against the radius for the active shape
  logic [DSW-1:0]     dsq;
  logic               hit;
  logic               covered_r;
  logic [CW-1:0]      col2_r, row2_r;
  logic [COLOR_W-1:0] color2_r;

  always_comb begin
    dsq = DSW'($unsigned(sqx1_r)) + DSW'($unsigned(sqy1_r));
    if (cfg.shape_mode) begin
      hit = d01_r <= DSW'(cfg.r2_full);
    end else if (cfg.len2 == '0) begin
      hit = d01_r <= DSW'(cfg.r2_half);
    end else begin
      hit = dsq <= DSW'(cfg.r2_cap);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      covered_r <= hit;
      col2_r    <= col1_r;
      row2_r    <= row1_r;
      color2_r  <= hit ? cfg.color : '0;
    end
  end

  assign out_res.valid     = v_r[NST-1];
  assign out_res.covered   = covered_r;
  assign out_res.out_col   = col2_r;
  assign out_res.out_row   = row2_r;
  assign out_res.out_color = color2_r;

  a_hold_res: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !out_res.ready |=> v_r[NST-1] && $stable(covered_r) && $stable(col2_r))
    else $error("result changed while stalled");

endmodule

@@ hdl/capsule_circle_pixel_coverage_unit.sv @@
// Top level of the capsule / circle pixel coverage unit.
//
//   channel   dir   beat contents
//   in_pix    in    pixel_col, pixel_row
//   out_res   out   covered, out_col, out_row, out_color
//   cfg_wr    in    index, data (register write, always ready)
//
// One pixel beat enters per cycle unless out_res stalls the pipe; each result
// passes 4 front stages, 5 divider stages of 3 quotient bits each and 3 back
// stages. Each stage advances when its successor has room, so a stall on
// out_res fills bubbles first and backs up to in_pix only when every stage
// holds a beat. rst_n clears all valid bits and config registers; derived
// config terms are registered and settle in the cycle after a write.
module capsule_circle_pixel_coverage_unit
  import ccpc_pkg::*;
#(
  parameter int ICON_PIXELS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ccpc_pix_if.sink   in_pix,
  ccpc_res_if.source out_res,
  ccpc_cfg_if.sink   cfg_wr
);

  localparam int CW = PIX_W;
  localparam int SW = $bits(geo_t) + 2 * CW;

  cfg_t           cfg;
  logic           f_valid, f_ready, d_valid, d_ready;
  logic [NW-1:0]  f_num_x, f_num_y;
  geo_t           f_geo, d_geo;
  logic [CW-1:0]  f_col, f_row, d_col, d_row;
  logic [QTW-1:0] d_qx, d_qy;
  logic [SW-1:0]  d_side;

  ccpc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  ccpc_front #(.ICON_PIXELS(ICON_PIXELS), .CW(CW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .cfg     (cfg),
    .o_valid (f_valid),
    .o_ready (f_ready),
    .o_num_x (f_num_x),
    .o_num_y (f_num_y),
    .o_geo   (f_geo),
    .o_col   (f_col),
    .o_row   (f_row)
  );

  ccpc_div #(.SW(SW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_ready (f_ready),
    .i_num_x (f_num_x),
    .i_num_y (f_num_y),
    .i_side  ({f_geo, f_col, f_row}),
    .len2    (cfg.len2),
    .o_valid (d_valid),
    .o_ready (d_ready),
    .o_qx    (d_qx),
    .o_qy    (d_qy),
    .o_side  (d_side)
  );

  assign {d_geo, d_col, d_row} = d_side;

  ccpc_back #(.CW(CW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (d_valid),
    .i_ready (d_ready),
    .i_qx    (d_qx),
    .i_qy    (d_qy),
    .i_geo   (d_geo),
    .i_col   (d_col),
    .i_row   (d_row),
    .cfg     (cfg),
    .out_res (out_res)
  );

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> out_res.valid && !out_res.ready)
    else $error("input blocked while the result side is free");

  a_div_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    !d_ready |-> out_res.valid && !out_res.ready)
    else $error("back pipe blocked while the result side is free");

endmodule

@@ verif/ccpc_if.sv @@
// Testbench copy note: channel interfaces live with the RTL; this file holds none.
`timescale 1ns / 1ps
package ccpc_tb_types;
  typedef struct {
    logic        covered;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [15:0] color;
  } cover_result_t;
endpackage

@@ verif/tb.sv @@
// Self-checking testbench of the capsule / circle pixel coverage unit.
`timescale 1ns / 1ps
module tb;
  import ccpc_pkg::*;
  import ccpc_tb_types::*;

  localparam int ICON = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 0;
  logic rst_n = 0;

  ccpc_pix_if #(.CW(6)) pix ();
  ccpc_res_if #(.CW(6)) res ();
  ccpc_cfg_if cfg ();

  capsule_circle_pixel_coverage_unit #(.ICON_PIXELS(ICON)) DUT (
    .clk(clk), .rst_n(rst_n), .in_pix(pix.sink), .out_res(res.source), .cfg_wr(cfg.sink)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow registers
  logic        sh_mode;
  logic [6:0]  sh_sx, sh_sy, sh_ex, sh_ey, sh_stroke;
  logic [15:0] sh_color;

  cover_result_t coverage_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint pixel_centre(input logic [5:0] p);
    return ((longint'(p) * 2 + 1) * 100 * 256) / (2 * ICON);
  endfunction

  function automatic logic point_in_disc(input longint px, py, cx, cy, r);
    return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r;
  endfunction

  function automatic cover_result_t predict_coverage(input logic [5:0] c, input logic [5:0] r);
    cover_result_t o;
    longint px, py, sx, sy, ex, ey, vx, vy, len2, rad, proj, cx, cy;
    logic hit;
    px = pixel_centre(c);
    py = pixel_centre(r);
    sx = longint'(sh_sx) * 256;
    sy = longint'(sh_sy) * 256;
    ex = longint'(sh_ex) * 256;
    ey = longint'(sh_ey) * 256;
    if (sh_mode) begin
      hit = point_in_disc(px, py, sx, sy, longint'(sh_stroke) * 256);
    end else begin
      vx = ex - sx;
      vy = ey - sy;
      len2 = vx * vx + vy * vy;
      rad = (longint'(sh_stroke) * 256) / 2;
      if (len2 == 0) begin
        hit = point_in_disc(px, py, sx, sy, longint'(sh_stroke / 2) * 256);
      end else begin
        proj = (px - sx) * vx + (py - sy) * vy;
        if (proj <= 0) begin
          cx = sx;
          cy = sy;
        end else if (proj >= len2) begin
          cx = ex;
          cy = ey;
        end else begin
          // SV signed division truncates toward zero
          cx = sx + (vx * proj) / len2;
          cy = sy + (vy * proj) / len2;
        end
        hit = point_in_disc(px, py, cx, cy, rad);
      end
    end
    o.covered = hit;
    o.col = c;
    o.row = r;
    o.color = hit ? sh_color : 16'h0;
    return o;
  endfunction

  // result ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) res.ready <= 0;
    else res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    cover_result_t exp_r;
    if (rst_n && res.valid && res.ready) begin
      if (coverage_q.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d", $time, res.out_col, res.out_row);
        errors++;
      end else begin
        exp_r = coverage_q.pop_front();
        if (res.covered !== exp_r.covered || res.out_col !== exp_r.col ||
            res.out_row !== exp_r.row || res.out_color !== exp_r.color) begin
          $display("%0t: mismatch expected cov=%0d col=%0d row=%0d color=%h",
                   $time, exp_r.covered, exp_r.col, exp_r.row, exp_r.color,
                   " actual cov=%0d col=%0d row=%0d color=%h",
                   res.covered, res.out_col, res.out_row, res.out_color);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    case (idx)
      REG_SHAPE_MODE:  sh_mode = value[0];
      REG_SEG_START_X: sh_sx = value[6:0];
      REG_SEG_START_Y: sh_sy = value[6:0];
      REG_SEG_END_X:   sh_ex = value[6:0];
      REG_SEG_END_Y:   sh_ey = value[6:0];
      REG_STROKE_SIZE: sh_stroke = value[6:0];
      REG_PAINT_COLOR: sh_color = value;
      default: ;
    endcase
    // let derived terms settle
    @(posedge clk);
  endtask

  task automatic wait_drained();
    pix.valid <= 0;
    while (coverage_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(input logic m, input logic [6:0] sx, sy, ex, ey, st,
                           input logic [15:0] color);
    // hold config writes until the pipe is empty
    wait_drained();
    write_reg(REG_SHAPE_MODE, 16'(m));
    write_reg(REG_SEG_START_X, 16'(sx));
    write_reg(REG_SEG_START_Y, 16'(sy));
    write_reg(REG_SEG_END_X, 16'(ex));
    write_reg(REG_SEG_END_Y, 16'(ey));
    write_reg(REG_STROKE_SIZE, 16'(st));
    write_reg(REG_PAINT_COLOR, color);
  endtask

  // send one pixel beat; an idle gap comes first at random
  task automatic send_pixel(input logic [5:0] c, input logic [5:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 0;
      @(posedge clk);
    end
    pix.valid <= 1;
    pix.pixel_col <= c;
    pix.pixel_row <= r;
    do @(posedge clk); while (!pix.ready);
    coverage_q.push_back(predict_coverage(c, r));
  endtask

  task automatic test_directed();
    set_shape(0, 0, 0, 0, 0, 0, 16'h0);
    send_pixel(0, 0);
    send_pixel(63, 63);
    set_shape(1, 50, 50, 0, 0, 100, 16'hFFFF);
    send_pixel(0, 63);
    send_pixel(63, 0);
    send_pixel(32, 32);
    set_shape(0, 127, 127, 0, 0, 127, 16'hA5A5);
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(21, 42);
    // zero-length segment with odd stroke
    set_shape(0, 40, 60, 40, 60, 33, 16'h5A5A);
    send_pixel(25, 38);
    send_pixel(30, 38);
    send_pixel(26, 45);
    // diagonal segment, interior projection with negative vector
    set_shape(0, 90, 10, 10, 90, 9, 16'h1234);
    send_pixel(32, 32);
    send_pixel(10, 50);
    send_pixel(60, 3);
    send_pixel(3, 60);
    send_pixel(0, 63);
    wait_drained();
  endtask

  task automatic random_shape();
    logic [6:0] sx, sy;
    sx = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
    sy = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
    set_shape(1'($urandom_range(1)), sx, sy,
              ($urandom_range(7) == 0) ? sx : 7'($urandom_range(127)),
              ($urandom_range(7) == 0) ? sy : 7'($urandom_range(100)),
              7'($urandom_range(127)), 16'($urandom));
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int items);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 60 == 0) begin
        wait_drained();
        random_shape();
      end
      send_pixel(6'($urandom_range(63)), 6'($urandom_range(63)));
    end
    wait_drained();
  endtask

  initial begin
    pix.valid = 0;
    pix.pixel_col = 0;
    pix.pixel_row = 0;
    cfg.valid = 0;
    cfg.index = REG_SHAPE_MODE;
    cfg.data = 0;
    sh_mode = 0;
    sh_sx = 0;
    sh_sy = 0;
    sh_ex = 0;
    sh_ey = 0;
    sh_stroke = 0;
    sh_color = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    recv_stall_pct = 0;
    test_directed();
    test_random_phase(15, 46, 540);
    test_random_phase(46, 15, 540);
    test_random_phase(0, 0, 540);
    if (errors == 0 && coverage_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/ccpc_pkg.sv
hdl/ccpc_if.sv
hdl/ccpc_cfg.sv
hdl/ccpc_front.sv
hdl/ccpc_div.sv
hdl/ccpc_back.sv
hdl/capsule_circle_pixel_coverage_unit.sv
verif/ccpc_if.sv
verif/tb.sv
